// ----- hw/rtl/lamp_dimming_mode_controller_assert.svh -----
// Assertion macros used by the lamp dimming mode controller checker.
`ifndef LAMP_DIMMING_MODE_CONTROLLER_ASSERT_SVH
`define LAMP_DIMMING_MODE_CONTROLLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LMC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LMC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/lmc_pkg.sv -----
// Types, constants and register codes of the lamp dimming mode controller.
package lmc_pkg;

   localparam int TIME_W  = 11;
   localparam int HOUR_W  = 5;
   localparam int MIN_W   = 6;
   localparam int LUX_W   = 16;
   localparam int LEVEL_W = 8;
   localparam int TIMES_W = 4 * TIME_W;
   localparam int LEVELS_W = 3 * LEVEL_W;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = TIMES_W;

   localparam logic [HOUR_W-1:0] LAST_HOUR = HOUR_W'(23);

   // Operation codes of an input transaction.
   localparam logic OP_EVAL = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Run modes.
   localparam logic [1:0] MODE_MANUAL  = 2'd0;
   localparam logic [1:0] MODE_AMBIENT = 2'd1;
   localparam logic [1:0] MODE_TIME    = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_RUN_MODE       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MANUAL_SWITCH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_BY_SCHED = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LUX_THRESHOLD  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCHED_TIMES    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SCHED_LEVELS   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FIXED_LEVEL    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_ABSENT_LEVEL   = 3'd7;

   typedef logic [TIME_W-1:0] time_type;

   typedef struct packed {
      logic               op;
      logic [HOUR_W-1:0]  now_hour;
      logic [MIN_W-1:0]   now_minute;
      logic [LUX_W-1:0]   lux_level;
      logic               presence;
   } item_type;

   typedef struct packed {
      logic [1:0]          run_mode;
      logic                manual_switch;
      logic                level_by_schedule;
      logic [LUX_W-1:0]    lux_threshold;
      logic [TIMES_W-1:0]  schedule_times;
      logic [LEVELS_W-1:0] scheduled_levels;
      logic [LEVEL_W-1:0]  fixed_level;
      logic [LEVEL_W-1:0]  absent_level;
   } cfg_type;

   typedef struct packed {
      logic               lamp_on;
      logic [LEVEL_W-1:0] target;
      logic [LEVEL_W-1:0] duty;
   } state_type;

endpackage

// ----- hw/rtl/lmc_window.sv -----
// Time window match test for one start and one stop time of day.
module lmc_window (
   input  lmc_pkg::time_type                start_time,
   input  lmc_pkg::time_type                stop_time,
   input  logic [lmc_pkg::HOUR_W-1:0]       now_hour,
   input  logic [lmc_pkg::MIN_W-1:0]        now_minute,
   output logic                             hit
);
   import lmc_pkg::*;

   logic [HOUR_W-1:0] hour_a;
   logic [HOUR_W-1:0] hour_b;
   logic [MIN_W-1:0]  min_a;
   logic [MIN_W-1:0]  min_b;
   logic              inner_hit;

   assign hour_a = start_time[TIME_W-1:MIN_W];
   assign min_a  = start_time[MIN_W-1:0];
   assign hour_b = stop_time[TIME_W-1:MIN_W];
   assign min_b  = stop_time[MIN_W-1:0];

   // A window whose start hour lies past its stop hour wraps over midnight.
   always_comb begin
      if (hour_a > hour_b) begin
         inner_hit = ((now_hour > hour_a) && (now_hour <= LAST_HOUR)) || (now_hour < hour_b);
      end else begin
         inner_hit = (now_hour > hour_a) && (now_hour < hour_b);
      end
   end

   // The boundary hours match on their minute limits.
   assign hit = inner_hit
             || ((now_hour == hour_a) && (now_minute >= min_a))
             || ((now_hour == hour_b) && (now_minute <= min_b));

endmodule

// ----- hw/rtl/lmc_eval.sv -----
// Next lamp state for one transaction: mode decision, level choice and fade step.
module lmc_eval (
   input  lmc_pkg::item_type  item,
   input  lmc_pkg::cfg_type   cfg,
   input  lmc_pkg::state_type state,
   output lmc_pkg::state_type state_next
);
   import lmc_pkg::*;

   time_type          slot [4];
   logic [2:0]        win_hit;
   logic              on_hit;
   logic              lux_low;
   logic [LEVEL_W-1:0] sched_target;
   state_type         lit_state;
   state_type         manual_state;
   state_type         off_state;
   state_type         tick_state;

   // Split the packed schedule into its four times.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         slot[k] = cfg.schedule_times[k*TIME_W +: TIME_W];
      end
   end

   // Three schedule windows and the overall on/off window.
   for (genvar k = 0; k < 3; k++) begin : g_win
      lmc_window u_win (
         .start_time (slot[k]),
         .stop_time  (slot[k+1]),
         .now_hour   (item.now_hour),
         .now_minute (item.now_minute),
         .hit        (win_hit[k])
      );
   end

   lmc_window u_on_win (
      .start_time (slot[0]),
      .stop_time  (slot[3]),
      .now_hour   (item.now_hour),
      .now_minute (item.now_minute),
      .hit        (on_hit)
   );

   assign lux_low = item.lux_level < cfg.lux_threshold;

   // The first matching window sets the level; with no match the target is kept.
   always_comb begin
      if (win_hit[0]) begin
         sched_target = cfg.scheduled_levels[0*LEVEL_W +: LEVEL_W];
      end else if (win_hit[1]) begin
         sched_target = cfg.scheduled_levels[1*LEVEL_W +: LEVEL_W];
      end else if (win_hit[2]) begin
         sched_target = cfg.scheduled_levels[2*LEVEL_W +: LEVEL_W];
      end else begin
         sched_target = state.target;
      end
   end

   // Lamp lit by the ambient or time mode; the schedule applies before presence.
   always_comb begin
      lit_state = state;
      lit_state.lamp_on = 1'b1;
      if (cfg.level_by_schedule) begin
         lit_state.target = sched_target;
      end
      if (!item.presence) begin
         lit_state.target = cfg.absent_level;
      end else if (!cfg.level_by_schedule) begin
         lit_state.target = cfg.fixed_level;
      end
   end

   // Lamp lit by the manual switch; the schedule is not consulted.
   always_comb begin
      manual_state = state;
      manual_state.lamp_on = 1'b1;
      if (!item.presence) begin
         manual_state.target = cfg.absent_level;
      end else if (!cfg.level_by_schedule) begin
         manual_state.target = cfg.fixed_level;
      end
   end

   assign off_state = '0;

   // A fade tick moves the duty one step toward the target.
   always_comb begin
      tick_state = state;
      if (state.target > state.duty) begin
         tick_state.duty = state.duty + LEVEL_W'(1);
      end else if (state.target < state.duty) begin
         tick_state.duty = state.duty - LEVEL_W'(1);
      end
   end

   // Select the outcome by operation and run mode.
   always_comb begin
      state_next = state;
      if (item.op == OP_TICK) begin
         state_next = tick_state;
      end else begin
         case (cfg.run_mode)
            MODE_MANUAL:  state_next = cfg.manual_switch ? manual_state : off_state;
            MODE_AMBIENT: state_next = lux_low ? lit_state : off_state;
            MODE_TIME:    state_next = on_hit ? lit_state : off_state;
            default:      state_next = state;
         endcase
      end
   end

endmodule

// ----- hw/rtl/lamp_dimming_mode_controller.sv -----
// Lamp dimming mode controller: input register, configuration and lamp state registers.
//
// Accepts one transaction every clock cycle while req_stall is low and returns exactly
// one result per transaction. The result is presented from the lamp state registers
// once its transaction leaves the input register, and a stalled result is held there.
// A transaction waits in the input register until the result register is empty or
// drained, then the mode, level and fade logic updates the lamp state registers, which
// also serve as the result register; the state update is combinational, which sets
// the one-per-cycle rate. While a result waits to be taken, the input register takes
// one more transaction if it is empty and then stalls the input. Configuration writes
// are always ready and take effect on the next evaluate transaction; write them only
// while the block is idle.
module lamp_dimming_mode_controller (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_op,
   input  logic [lmc_pkg::HOUR_W-1:0]        req_now_hour,
   input  logic [lmc_pkg::MIN_W-1:0]         req_now_minute,
   input  logic [lmc_pkg::LUX_W-1:0]         req_lux_level,
   input  logic                              req_presence,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [lmc_pkg::LEVEL_W-1:0]       rsp_duty,
   output logic                              rsp_lamp_on,
   output logic [lmc_pkg::LEVEL_W-1:0]       rsp_target,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lmc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lmc_pkg::CSR_DATA_W-1:0]    csr_data
);
   import lmc_pkg::*;

   item_type  item_ff,  item_in;
   logic      item_valid_ff, item_valid_in;
   cfg_type   cfg_ff,   cfg_in;
   state_type state_ff, state_in;
   state_type state_next;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_take;
   logic      advance;

   // The input register moves on when the result register is empty or drained.
   assign advance   = item_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = item_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      item_in       = item_ff;
      item_valid_in = item_valid_ff;
      if (req_take) begin
         item_in.op         = req_op;
         item_in.now_hour   = req_now_hour;
         item_in.now_minute = req_now_minute;
         item_in.lux_level  = req_lux_level;
         item_in.presence   = req_presence;
         item_valid_in      = 1'b1;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end
   end

   // Configuration register writes.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_RUN_MODE:       cfg_in.run_mode          = csr_data[1:0];
            CSR_MANUAL_SWITCH:  cfg_in.manual_switch     = csr_data[0];
            CSR_LEVEL_BY_SCHED: cfg_in.level_by_schedule = csr_data[0];
            CSR_LUX_THRESHOLD:  cfg_in.lux_threshold     = csr_data[LUX_W-1:0];
            CSR_SCHED_TIMES:    cfg_in.schedule_times    = csr_data[TIMES_W-1:0];
            CSR_SCHED_LEVELS:   cfg_in.scheduled_levels  = csr_data[LEVELS_W-1:0];
            CSR_FIXED_LEVEL:    cfg_in.fixed_level       = csr_data[LEVEL_W-1:0];
            CSR_ABSENT_LEVEL:   cfg_in.absent_level      = csr_data[LEVEL_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   // Lamp state update for the transaction in the input register.
   lmc_eval u_eval (
      .item       (item_ff),
      .cfg        (cfg_ff),
      .state      (state_ff),
      .state_next (state_next)
   );

   assign state_in     = advance ? state_next : state_ff;
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         cfg_ff        <= '0;
         state_ff      <= '0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         cfg_ff        <= cfg_in;
         state_ff      <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   // The state registers hold the result until it is taken.
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_duty    = state_ff.duty;
   assign rsp_lamp_on = state_ff.lamp_on;
   assign rsp_target  = state_ff.target;

endmodule

// ----- hw/rtl/lmc_checker.sv -----
// Port-level checker for the lamp dimming mode controller and its bind statement.
`include "lamp_dimming_mode_controller_assert.svh"

module lmc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [lmc_pkg::LEVEL_W-1:0]       rsp_duty,
   input logic                              rsp_lamp_on,
   input logic [lmc_pkg::LEVEL_W-1:0]       rsp_target
);
   import lmc_pkg::*;

   logic [LEVEL_W-1:0] last_duty_ff, last_duty_in;
   logic [LEVEL_W:0]   duty_up;
   logic [LEVEL_W:0]   duty_down;

   // Duty of the last result that was taken.
   assign last_duty_in = (rsp_valid && !rsp_stall) ? rsp_duty : last_duty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_duty_ff <= '0;
      end else begin
         last_duty_ff <= last_duty_in;
      end
   end

   assign duty_up   = {1'b0, last_duty_ff} + (LEVEL_W+1)'(1);
   assign duty_down = {1'b0, last_duty_ff} - (LEVEL_W+1)'(1);

   // A stalled result transaction keeps its payload.
   `LMC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_duty) && $stable(rsp_lamp_on) && $stable(rsp_target),
      "result changed while stalled")

   // A lamp reported off has both its duty and target at zero.
   `LMC_ASSERT_SAME(a_off_dark, clock, reset, rsp_valid && !rsp_lamp_on,
      (rsp_duty == '0) && (rsp_target == '0), "lamp off with nonzero level")

   // The duty fades by at most one step per result, or drops to zero.
   `LMC_ASSERT_SAME(a_fade_step, clock, reset, rsp_valid,
      (rsp_duty == last_duty_ff) || ({1'b0, rsp_duty} == duty_up)
      || ({1'b0, rsp_duty} == duty_down) || (rsp_duty == '0),
      "duty jumped by more than one step")

endmodule

bind lamp_dimming_mode_controller lmc_checker u_lmc_checker (.*);

// ----- test/tb_lamp_dimming_mode_controller.sv -----
// Self-checking testbench for the lamp dimming mode controller, with directed and random traffic.
`timescale 1ns / 1ps

module tb_lamp_dimming_mode_controller;
   import lmc_pkg::*;

   // Run mode code that selects no behavior at all.
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   // Cycles to let pass once the last result is in, before a register write or the end.
   localparam int SETTLE_CYCLES = 4;
   // Cycles without any transaction before the run is declared hung.
   localparam int WATCHDOG_LIMIT = 1000;
   // Length of the long result-side hold-off.
   localparam int LONG_HOLD_CYCLES = 120;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_op = 1'b0;
   logic [HOUR_W-1:0]     req_now_hour = '0;
   logic [MIN_W-1:0]      req_now_minute = '0;
   logic [LUX_W-1:0]      req_lux_level = '0;
   logic                  req_presence = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [LEVEL_W-1:0]    rsp_duty;
   logic                  rsp_lamp_on;
   logic [LEVEL_W-1:0]    rsp_target;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Shadow of the lamp state and of the registers, and the lamp states still owed.
   state_type lamp_shadow = '0;
   cfg_type   regs_shadow = '0;
   state_type lamp_results_due[$];

   int fail_count = 0;
   int burst_left = 0;
   bit no_gaps = 1'b0;
   int rsp_hold_request = 0;

   lamp_dimming_mode_controller dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_now_hour   (req_now_hour),
      .req_now_minute (req_now_minute),
      .req_lux_level  (req_lux_level),
      .req_presence   (req_presence),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_duty       (rsp_duty),
      .rsp_lamp_on    (rsp_lamp_on),
      .rsp_target     (rsp_target),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   // Free-running clock.
   initial begin
      forever #5 clock = ~clock;
   end

   // Packs an hour and a minute into one schedule time.
   function automatic time_type clock_point(input int hour, input int minute);
      return {HOUR_W'(hour), MIN_W'(minute)};
   endfunction

   // Picks schedule time k out of the packed schedule register.
   function automatic time_type sched_point(input cfg_type c, input int k);
      return c.schedule_times[TIME_W*k +: TIME_W];
   endfunction

   // True when hour h, minute m falls in the span from a to b, wrapping past midnight
   // when a's hour is later than b's.
   function automatic logic time_in_span(input time_type a, input time_type b,
                                         input logic [HOUR_W-1:0] h,
                                         input logic [MIN_W-1:0] m);
      logic [HOUR_W-1:0] ha;
      logic [HOUR_W-1:0] hb;
      logic [MIN_W-1:0]  ma;
      logic [MIN_W-1:0]  mb;
      logic              hit;
      ha = a[TIME_W-1:MIN_W];
      ma = a[MIN_W-1:0];
      hb = b[TIME_W-1:MIN_W];
      mb = b[MIN_W-1:0];
      if (ha > hb) begin
         hit = (h > ha && h <= LAST_HOUR) || (h < hb);
      end else begin
         hit = (h > ha) && (h < hb);
      end
      hit = hit || (h == ha && m >= ma) || (h == hb && m <= mb);
      return hit;
   endfunction

   // Lamp state after one transaction, given the state before it and the registers.
   function automatic state_type next_lamp_state(input state_type s, input cfg_type c,
                                                 input item_type it);
      logic turn_on;
      logic use_sched;
      logic matched;
      if (it.op == OP_TICK) begin
         if (s.target > s.duty) begin
            s.duty = s.duty + 1'b1;
         end else if (s.target < s.duty) begin
            s.duty = s.duty - 1'b1;
         end
         return s;
      end
      case (c.run_mode)
         MODE_MANUAL: begin
            turn_on = c.manual_switch;
            use_sched = 1'b0;
         end
         MODE_AMBIENT: begin
            turn_on = it.lux_level < c.lux_threshold;
            use_sched = c.level_by_schedule;
         end
         MODE_TIME: begin
            turn_on = time_in_span(sched_point(c, 0), sched_point(c, 3),
                                   it.now_hour, it.now_minute);
            use_sched = c.level_by_schedule;
         end
         default: begin
            return s;
         end
      endcase
      // Switching off clears the whole lamp state.
      if (!turn_on) begin
         return '0;
      end
      s.lamp_on = 1'b1;
      // The first matching schedule window loads its level; no match keeps the target.
      matched = 1'b0;
      if (use_sched) begin
         for (int k = 0; k < 3; k++) begin
            if (!matched && time_in_span(sched_point(c, k), sched_point(c, k + 1),
                                         it.now_hour, it.now_minute)) begin
               s.target = c.scheduled_levels[LEVEL_W*k +: LEVEL_W];
               matched = 1'b1;
            end
         end
      end
      if (!it.presence) begin
         s.target = c.absent_level;
      end else if (!c.level_by_schedule) begin
         s.target = c.fixed_level;
      end
      return s;
   endfunction

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) begin
         $display("mismatch at %0t: %s", $time, msg);
      end
   endfunction

   // Offers one transaction in the current burst and records the lamp state it should yield.
   task automatic send_item(input item_type it);
      int gap;
      if (burst_left == 0) begin
         gap = no_gaps ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_op         <= it.op;
      req_now_hour   <= it.now_hour;
      req_now_minute <= it.now_minute;
      req_lux_level  <= it.lux_level;
      req_presence   <= it.presence;
      do @(posedge clock); while (req_stall !== 1'b0);
      lamp_shadow = next_lamp_state(lamp_shadow, regs_shadow, it);
      lamp_results_due.push_back(lamp_shadow);
   endtask

   task automatic send_eval(input logic [HOUR_W-1:0] h, input logic [MIN_W-1:0] m,
                            input logic [LUX_W-1:0] lux, input logic present);
      item_type it;
      it.op = OP_EVAL;
      it.now_hour = h;
      it.now_minute = m;
      it.lux_level = lux;
      it.presence = present;
      send_item(it);
   endtask

   task automatic send_tick();
      item_type it;
      it = '0;
      it.op = OP_TICK;
      send_item(it);
   endtask

   // Stops offering and waits until every owed result has been taken.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (lamp_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write; the valid stays up so that writes can follow back to back.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
   endtask

   // Writes every register from c; only called while the block is idle.
   task automatic program_config(input cfg_type c);
      write_csr(CSR_RUN_MODE,       CSR_DATA_W'(c.run_mode));
      write_csr(CSR_MANUAL_SWITCH,  CSR_DATA_W'(c.manual_switch));
      write_csr(CSR_LEVEL_BY_SCHED, CSR_DATA_W'(c.level_by_schedule));
      write_csr(CSR_LUX_THRESHOLD,  CSR_DATA_W'(c.lux_threshold));
      write_csr(CSR_SCHED_TIMES,    CSR_DATA_W'(c.schedule_times));
      write_csr(CSR_SCHED_LEVELS,   CSR_DATA_W'(c.scheduled_levels));
      write_csr(CSR_FIXED_LEVEL,    CSR_DATA_W'(c.fixed_level));
      write_csr(CSR_ABSENT_LEVEL,   CSR_DATA_W'(c.absent_level));
      csr_valid <= 1'b0;
      regs_shadow = c;
   endtask

   function automatic logic [LEVEL_W-1:0] rand_level();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return LEVEL_W'($urandom);
      endcase
   endfunction

   // Mostly legal clock times, now and then any 11-bit value.
   function automatic time_type rand_clock_point();
      if ($urandom_range(0, 9) == 0) begin
         return TIME_W'($urandom_range(0, 2047));
      end
      return clock_point($urandom_range(0, 23), $urandom_range(0, 59));
   endfunction

   function automatic cfg_type rand_config();
      cfg_type c;
      int pick;
      pick = $urandom_range(0, 9);
      c.run_mode = (pick < 3) ? MODE_MANUAL : (pick < 6) ? MODE_AMBIENT :
                   (pick < 9) ? MODE_TIME : MODE_UNUSED;
      c.manual_switch = ($urandom_range(0, 3) != 0);
      c.level_by_schedule = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
         0: c.lux_threshold = '0;
         1: c.lux_threshold = '1;
         default: c.lux_threshold = LUX_W'($urandom);
      endcase
      c.schedule_times = {rand_clock_point(), rand_clock_point(),
                          rand_clock_point(), rand_clock_point()};
      c.scheduled_levels = {rand_level(), rand_level(), rand_level()};
      c.fixed_level = rand_level();
      c.absent_level = rand_level();
      return c;
   endfunction

   // Random transaction; lux readings cluster around the threshold to exercise the compare.
   function automatic item_type rand_item(input cfg_type c, input int tick_pct,
                                          input int present_pct);
      item_type it;
      it.op = ($urandom_range(0, 99) < tick_pct) ? OP_TICK : OP_EVAL;
      it.now_hour = ($urandom_range(0, 19) == 0) ? HOUR_W'($urandom_range(0, 31)) :
                    HOUR_W'($urandom_range(0, 23));
      it.now_minute = ($urandom_range(0, 19) == 0) ? MIN_W'($urandom_range(0, 63)) :
                      MIN_W'($urandom_range(0, 59));
      case ($urandom_range(0, 3))
         0: it.lux_level = c.lux_threshold + LUX_W'($urandom_range(0, 4)) - LUX_W'(2);
         1: it.lux_level = LUX_W'($urandom);
         2: it.lux_level = $urandom_range(0, 1) ? '1 : '0;
         default: it.lux_level = (c.lux_threshold == 0) ? '0 :
                                 LUX_W'($urandom_range(0, c.lux_threshold - 1));
      endcase
      it.presence = ($urandom_range(0, 99) < present_pct);
      return it;
   endfunction

   // Every register still holds its reset value, so the manual switch is off.
   task automatic test_reset_defaults();
      send_eval(0, 0, 0, 1'b0);
      send_tick();
      wait_idle();
   endtask

   // Manual switch on and off, presence both ways, and the schedule flag keeping the target.
   task automatic test_manual_mode();
      cfg_type c;
      c = '0;
      c.run_mode = MODE_MANUAL;
      c.manual_switch = 1'b1;
      c.fixed_level = 8'hFF;
      c.absent_level = 8'h80;
      program_config(c);
      send_eval(12, 0, 0, 1'b1);
      send_tick();
      send_tick();
      send_eval(12, 0, 0, 1'b0);
      wait_idle();
      c.level_by_schedule = 1'b1;
      c.scheduled_levels = 24'h123456;
      program_config(c);
      send_eval(12, 0, 0, 1'b1);
      wait_idle();
      c.manual_switch = 1'b0;
      program_config(c);
      send_eval(12, 0, 0, 1'b1);
      send_tick();
      wait_idle();
   endtask

   // Threshold extremes, lux at and below the threshold, and a schedule with no match.
   task automatic test_ambient_mode();
      cfg_type c;
      c = '0;
      c.run_mode = MODE_AMBIENT;
      c.manual_switch = 1'b1;
      c.fixed_level = 8'h01;
      c.absent_level = 8'h7F;
      program_config(c);
      send_eval(10, 0, 16'h0000, 1'b1);
      wait_idle();
      c.lux_threshold = 16'hFFFF;
      program_config(c);
      send_eval(10, 0, 16'hFFFF, 1'b1);
      send_eval(10, 0, 16'hFFFE, 1'b1);
      send_eval(10, 0, 16'h0000, 1'b0);
      wait_idle();
      // At 3:00 no schedule window matches, so the target from 12:00 stays.
      c.level_by_schedule = 1'b1;
      c.schedule_times = {clock_point(22, 45), clock_point(18, 15),
                          clock_point(12, 0), clock_point(6, 30)};
      c.scheduled_levels = {8'd30, 8'd20, 8'd10};
      program_config(c);
      send_eval(12, 0, 0, 1'b1);
      send_eval(3, 0, 0, 1'b1);
      send_tick();
      wait_idle();
   endtask

   // Window edges with schedule levels, a window across midnight, and the unused mode.
   task automatic test_time_window();
      cfg_type c;
      c = '0;
      c.run_mode = MODE_TIME;
      c.level_by_schedule = 1'b1;
      c.schedule_times = {clock_point(22, 45), clock_point(18, 15),
                          clock_point(12, 0), clock_point(6, 30)};
      c.scheduled_levels = {8'd30, 8'd20, 8'd10};
      c.fixed_level = 8'hAA;
      c.absent_level = 8'h55;
      program_config(c);
      send_eval(6, 29, 0, 1'b1);
      send_eval(6, 30, 0, 1'b1);
      send_eval(12, 0, 0, 1'b1);
      send_eval(15, 0, 0, 1'b1);
      send_eval(22, 45, 0, 1'b1);
      send_eval(23, 0, 0, 1'b1);
      send_eval(18, 15, 0, 1'b0);
      wait_idle();
      c.level_by_schedule = 1'b0;
      c.fixed_level = 8'hFF;
      c.schedule_times = {clock_point(5, 59), clock_point(3, 0),
                          clock_point(1, 0), clock_point(22, 0)};
      program_config(c);
      send_eval(6, 0, 0, 1'b1);
      send_eval(23, 59, 0, 1'b1);
      send_tick();
      wait_idle();
      // The unused mode leaves the lit lamp exactly as it is.
      c.run_mode = MODE_UNUSED;
      program_config(c);
      send_eval(23, 59, 0, 1'b0);
      wait_idle();
   endtask

   // Phases of random traffic, each under its own register setting, extremes first.
   task automatic test_random_traffic();
      cfg_type c;
      int tick_pct;
      int present_pct;
      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            0: begin
               c = '1;
               c.run_mode = MODE_AMBIENT;
            end
            1: begin
               c = '1;
               c.run_mode = MODE_TIME;
            end
            2: begin
               c = '0;
               c.manual_switch = 1'b1;
            end
            default: c = rand_config();
         endcase
         tick_pct = $urandom_range(10, 85);
         present_pct = $urandom_range(20, 100);
         program_config(c);
         repeat (170) send_item(rand_item(c, tick_pct, present_pct));
         wait_idle();
      end
   endtask

   // The result side holds off for a long stretch while transactions keep coming.
   task automatic test_result_backpressure();
      cfg_type c;
      c = rand_config();
      c.run_mode = MODE_MANUAL;
      c.manual_switch = 1'b1;
      program_config(c);
      no_gaps = 1'b1;
      rsp_hold_request = LONG_HOLD_CYCLES;
      repeat (80) send_item(rand_item(c, 50, 70));
      no_gaps = 1'b0;
      wait_idle();
   endtask

   // Result-side stall pattern, with a long hold-off on request.
   initial begin : result_stall_pattern
      int stall_pct;
      int pattern_left;
      int hold_left;
      stall_pct = 0;
      pattern_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_hold_request > 0) begin
            hold_left = rsp_hold_request - 1;
            rsp_hold_request = 0;
            rsp_stall <= 1'b1;
         end else begin
            if (pattern_left == 0) begin
               pattern_left = $urandom_range(20, 200);
               case ($urandom_range(0, 4))
                  0, 1: stall_pct = 0;
                  2: stall_pct = 25;
                  3: stall_pct = 50;
                  default: stall_pct = 85;
               endcase
            end
            pattern_left--;
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   // Compare each result transaction with the oldest owed lamp state.
   always @(posedge clock) begin : check_results
      state_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (lamp_results_due.size() == 0) begin
            note_failure($sformatf("unexpected result duty %0d lamp_on %0b target %0d",
                                   rsp_duty, rsp_lamp_on, rsp_target));
         end else begin
            want = lamp_results_due.pop_front();
            if (rsp_duty !== want.duty || rsp_lamp_on !== want.lamp_on ||
                rsp_target !== want.target) begin
               note_failure($sformatf(
                  "duty exp %0d got %0d, lamp_on exp %0b got %0b, target exp %0d got %0d",
                  want.duty, rsp_duty, want.lamp_on, rsp_lamp_on, want.target, rsp_target));
            end
         end
      end
   end

   // Ends a hung run: too many cycles in a row without any transaction.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall) ||
             (csr_valid && csr_ready === 1'b1)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("lamp_dimming_mode_controller regression: fail");
      $finish;
   end

   // Reset, then the tests in turn, then the verdict.
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_manual_mode();
      test_ambient_mode();
      test_time_window();
      test_random_traffic();
      test_result_backpressure();
      wait_idle();
      if (fail_count == 0) begin
         $display("lamp_dimming_mode_controller regression: pass");
      end else begin
         $display("lamp_dimming_mode_controller regression: fail");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/lmc_pkg.sv
hw/rtl/lmc_window.sv
hw/rtl/lmc_eval.sv
hw/rtl/lamp_dimming_mode_controller.sv
hw/rtl/lmc_checker.sv
test/tb_lamp_dimming_mode_controller.sv
